### rtl/tpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle point query package
// Widths, register indexes and edge selection codes shared by the block.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int COORD_BITS = 16;
    localparam int LIM_W      = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = 2 * DIFF_W + 1;
    localparam int NUM_W      = 3 * DIFF_W;
    localparam int NEAR_W     = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int CFG_W      = (COORD_BITS > LIM_W) ? COORD_BITS : LIM_W;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_C_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_LIM = 3'd6;

    localparam logic [LIM_W-1:0] LIM_RESET = 32'd7;

    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_PROJ
    } sel_t;

    // Edges in order AB, AC, BC; the opposite vertex is the one not on the edge.
    function automatic logic [1:0] edge_start(input int e);
        logic [1:0] r;
        case (e)
            0: r = 2'd0;
            1: r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] edge_end(input int e);
        logic [1:0] r;
        case (e)
            0: r = 2'd1;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] edge_opp(input int e);
        logic [1:0] r;
        case (e)
            0: r = 2'd2;
            1: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/triangle_point_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle point query
// Inside test, near-vertex test and closest edge point for one query point
// against a triangle held in configuration registers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// config    in         cfg_wr_en              cfg_index, cfg_data
// query     in         start (busy is low)    query_x, query_y
// result    out        done, one cycle        inside_res, near_vertex,
//                                             closest_x, closest_y
//
// One query beat is taken every cycle; busy never rises.
// A result passes stages 1 to 4, the divider load stage, the restoring divider
// that yields one quotient bit per stage, and post stages 1 to 3.
// Reset clears the valid bits of every stage and loads the register defaults.
// The result beat cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module triangle_point_query (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [tpq_pkg::IDX_W-1:0]             cfg_index,
    input  logic [tpq_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] query_y,
    output logic                                  done,
    output logic                                  inside_res,
    output logic                                  near_vertex,
    output logic signed [tpq_pkg::COORD_BITS-1:0] closest_x,
    output logic signed [tpq_pkg::COORD_BITS-1:0] closest_y
);

    localparam int C   = tpq_pkg::COORD_BITS;
    localparam int D   = tpq_pkg::DIFF_W;
    localparam int P   = tpq_pkg::PROD_W;
    localparam int S   = tpq_pkg::SUM_W;
    localparam int N   = tpq_pkg::NUM_W;
    localparam int NW  = tpq_pkg::NEAR_W;
    localparam int LAT = D + 8;

    // Configuration registers.
    logic signed [C-1:0]           vx_reg [0:2];
    logic signed [C-1:0]           vy_reg [0:2];
    logic [tpq_pkg::LIM_W-1:0]     lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            lim_reg <= tpq_pkg::LIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tpq_pkg::REG_A_X: vx_reg[0] <= cfg_data[C-1:0];
                tpq_pkg::REG_A_Y: vy_reg[0] <= cfg_data[C-1:0];
                tpq_pkg::REG_B_X: vx_reg[1] <= cfg_data[C-1:0];
                tpq_pkg::REG_B_Y: vy_reg[1] <= cfg_data[C-1:0];
                tpq_pkg::REG_C_X: vx_reg[2] <= cfg_data[C-1:0];
                tpq_pkg::REG_C_Y: vy_reg[2] <= cfg_data[C-1:0];
                tpq_pkg::REG_LIM: lim_reg   <= cfg_data[tpq_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- Stage 1: differences ----------------
    logic                v1_reg;
    logic signed [D-1:0] px1_reg, py1_reg;
    logic signed [D-1:0] edx1_reg [0:2], edy1_reg [0:2];
    logic signed [D-1:0] wx1_reg [0:2], wy1_reg [0:2];
    logic signed [D-1:0] ox1_reg [0:2], oy1_reg [0:2];
    logic signed [D-1:0] vdx1_reg [0:2], vdy1_reg [0:2];
    logic signed [D-1:0] qx_ext, qy_ext;
    logic signed [D-1:0] vxe [0:2], vye [0:2];

    always_comb
    begin
        qx_ext = {query_x[C-1], query_x};
        qy_ext = {query_y[C-1], query_y};
        for (int i = 0; i < 3; i++)
        begin
            vxe[i] = {vx_reg[i][C-1], vx_reg[i]};
            vye[i] = {vy_reg[i][C-1], vy_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg <= qx_ext;
        py1_reg <= qy_ext;
        for (int e = 0; e < 3; e++)
        begin
            edx1_reg[e] <= vxe[tpq_pkg::edge_end(e)] - vxe[tpq_pkg::edge_start(e)];
            edy1_reg[e] <= vye[tpq_pkg::edge_end(e)] - vye[tpq_pkg::edge_start(e)];
            wx1_reg[e]  <= qx_ext - vxe[tpq_pkg::edge_start(e)];
            wy1_reg[e]  <= qy_ext - vye[tpq_pkg::edge_start(e)];
            ox1_reg[e]  <= vxe[tpq_pkg::edge_opp(e)] - vxe[tpq_pkg::edge_start(e)];
            oy1_reg[e]  <= vye[tpq_pkg::edge_opp(e)] - vye[tpq_pkg::edge_start(e)];
            vdx1_reg[e] <= qx_ext - vxe[e];
            vdy1_reg[e] <= qy_ext - vye[e];
        end
    end

    // ---------------- Stage 2: products ----------------
    logic                v2_reg;
    logic signed [D-1:0] px2_reg, py2_reg;
    logic signed [D-1:0] edx2_reg [0:2], edy2_reg [0:2];
    logic signed [P-1:0] c1a2_reg [0:2], c1b2_reg [0:2];
    logic signed [P-1:0] c2a2_reg [0:2], c2b2_reg [0:2];
    logic signed [P-1:0] da2_reg [0:2], db2_reg [0:2];
    logic signed [P-1:0] la2_reg [0:2], lb2_reg [0:2];
    logic signed [P-1:0] qa2_reg [0:2], qb2_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;
        for (int e = 0; e < 3; e++)
        begin
            edx2_reg[e] <= edx1_reg[e];
            edy2_reg[e] <= edy1_reg[e];
            c1a2_reg[e] <= edx1_reg[e] * wy1_reg[e];
            c1b2_reg[e] <= wx1_reg[e] * edy1_reg[e];
            c2a2_reg[e] <= edx1_reg[e] * oy1_reg[e];
            c2b2_reg[e] <= ox1_reg[e] * edy1_reg[e];
            da2_reg[e]  <= wx1_reg[e] * edx1_reg[e];
            db2_reg[e]  <= wy1_reg[e] * edy1_reg[e];
            la2_reg[e]  <= edx1_reg[e] * edx1_reg[e];
            lb2_reg[e]  <= edy1_reg[e] * edy1_reg[e];
            qa2_reg[e]  <= vdx1_reg[e] * vdx1_reg[e];
            qb2_reg[e]  <= vdy1_reg[e] * vdy1_reg[e];
        end
    end

    // ---------------- Stage 3: sums and sign tests ----------------
    logic                v3_reg, ins3_reg, near3_reg;
    logic signed [D-1:0] px3_reg, py3_reg;
    logic signed [D-1:0] edx3_reg [0:2], edy3_reg [0:2];
    logic signed [S-1:0] dot3_reg [0:2], len3_reg [0:2];
    logic signed [S-1:0] cr1 [0:2], cr2 [0:2], vsq [0:2];
    logic                ins_c, near_c;

    always_comb
    begin
        ins_c  = 1'b1;
        near_c = 1'b0;
        for (int e = 0; e < 3; e++)
        begin
            cr1[e] = S'(c1a2_reg[e]) - S'(c1b2_reg[e]);
            cr2[e] = S'(c2a2_reg[e]) - S'(c2b2_reg[e]);
            vsq[e] = S'(qa2_reg[e]) + S'(qb2_reg[e]);
            // Opposite strict signs put the point on the far side of this edge.
            if ((!cr1[e][S-1] && cr1[e] != '0 && cr2[e][S-1]) ||
                (cr1[e][S-1] && !cr2[e][S-1] && cr2[e] != '0))
            begin
                ins_c = 1'b0;
            end
            if (NW'(unsigned'(vsq[e])) < NW'(lim_reg))
            begin
                near_c = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ins3_reg  <= ins_c;
        near3_reg <= near_c;
        px3_reg   <= px2_reg;
        py3_reg   <= py2_reg;
        for (int e = 0; e < 3; e++)
        begin
            edx3_reg[e] <= edx2_reg[e];
            edy3_reg[e] <= edy2_reg[e];
            dot3_reg[e] <= S'(da2_reg[e]) + S'(db2_reg[e]);
            len3_reg[e] <= S'(la2_reg[e]) + S'(lb2_reg[e]);
        end
    end

    // ---------------- Stage 4: clamp choice, partial products ----------------
    logic                v4_reg, ins4_reg, near4_reg;
    logic signed [D-1:0] px4_reg, py4_reg;
    tpq_pkg::sel_t       sel4_reg [0:2];
    logic [S-1:0]        len4_reg [0:2];
    logic                neg4_reg [0:5];
    logic [P-1:0]        plo4_reg [0:5], phi4_reg [0:5];
    tpq_pkg::sel_t       sel_c [0:2];
    logic [D-1:0]        mag_c [0:5];
    logic [P-1:0]        dot_u [0:2];
    logic signed [D-1:0] ed_c [0:5];

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            if (len3_reg[e] == '0 || dot3_reg[e][S-1])
            begin
                sel_c[e] = tpq_pkg::SEL_START;
            end
            else if (dot3_reg[e] > len3_reg[e])
            begin
                sel_c[e] = tpq_pkg::SEL_END;
            end
            else
            begin
                sel_c[e] = tpq_pkg::SEL_PROJ;
            end
            dot_u[e]      = dot3_reg[e][P-1:0];
            ed_c[2*e]     = edx3_reg[e];
            ed_c[2*e + 1] = edy3_reg[e];
        end
        for (int c = 0; c < 6; c++)
        begin
            mag_c[c] = ed_c[c][D-1] ? D'(-ed_c[c]) : D'(ed_c[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ins4_reg  <= ins3_reg;
        near4_reg <= near3_reg;
        px4_reg   <= px3_reg;
        py4_reg   <= py3_reg;
        for (int e = 0; e < 3; e++)
        begin
            sel4_reg[e] <= sel_c[e];
            len4_reg[e] <= len3_reg[e];
        end
        for (int c = 0; c < 6; c++)
        begin
            neg4_reg[c] <= ed_c[c][D-1];
            plo4_reg[c] <= mag_c[c] * dot_u[c/2][D-1:0];
            phi4_reg[c] <= mag_c[c] * dot_u[c/2][P-1:D];
        end
    end

    // ---------------- Divider: stage 0 loads numerators ----------------
    logic                dv_reg   [0:D];
    logic                dins_reg [0:D];
    logic                dnear_reg[0:D];
    logic signed [D-1:0] dpx_reg  [0:D];
    logic signed [D-1:0] dpy_reg  [0:D];
    tpq_pkg::sel_t       dsel_reg [0:D][0:2];
    logic [S-1:0]        dlen_reg [0:D][0:2];
    logic                dneg_reg [0:D][0:5];
    logic [N-1:0]        rem_reg  [0:D][0:5];
    logic [D-1:0]        quo_reg  [0:D][0:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dins_reg[0]  <= ins4_reg;
        dnear_reg[0] <= near4_reg;
        dpx_reg[0]   <= px4_reg;
        dpy_reg[0]   <= py4_reg;
        for (int e = 0; e < 3; e++)
        begin
            dsel_reg[0][e] <= sel4_reg[e];
            dlen_reg[0][e] <= len4_reg[e];
        end
        for (int c = 0; c < 6; c++)
        begin
            dneg_reg[0][c] <= neg4_reg[c];
            rem_reg[0][c]  <= (N'(phi4_reg[c]) << D) + N'(plo4_reg[c]);
            quo_reg[0][c]  <= '0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < D; j++)
    begin : g_div
        localparam int K = D - 1 - j;
        logic [N-1:0] trial [0:5];
        logic         fits  [0:5];

        always_comb
        begin
            for (int c = 0; c < 6; c++)
            begin
                trial[c] = N'(dlen_reg[j][c/2]) << K;
                fits[c]  = rem_reg[j][c] >= trial[c];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dins_reg[j+1]  <= dins_reg[j];
            dnear_reg[j+1] <= dnear_reg[j];
            dpx_reg[j+1]   <= dpx_reg[j];
            dpy_reg[j+1]   <= dpy_reg[j];
            for (int e = 0; e < 3; e++)
            begin
                dsel_reg[j+1][e] <= dsel_reg[j][e];
                dlen_reg[j+1][e] <= dlen_reg[j][e];
            end
            for (int c = 0; c < 6; c++)
            begin
                dneg_reg[j+1][c] <= dneg_reg[j][c];
                rem_reg[j+1][c]  <= fits[c] ? rem_reg[j][c] - trial[c] : rem_reg[j][c];
                quo_reg[j+1][c]  <= quo_reg[j][c] | (fits[c] ? D'(1) << K : D'(0));
            end
        end
    end

    // ---------------- Post 1: edge points ----------------
    logic                e1v_reg, e1ins_reg, e1near_reg;
    logic signed [D-1:0] e1px_reg, e1py_reg;
    logic signed [C-1:0] ept_reg [0:5];
    logic signed [C-1:0] ept_c   [0:5];
    logic signed [D:0]   qs_c    [0:5];
    logic signed [C-1:0] vs_c, ve_c;

    always_comb
    begin
        for (int c = 0; c < 6; c++)
        begin
            if (c % 2 == 0)
            begin
                vs_c = vx_reg[tpq_pkg::edge_start(c/2)];
                ve_c = vx_reg[tpq_pkg::edge_end(c/2)];
            end
            else
            begin
                vs_c = vy_reg[tpq_pkg::edge_start(c/2)];
                ve_c = vy_reg[tpq_pkg::edge_end(c/2)];
            end
            qs_c[c] = dneg_reg[D][c] ? -signed'({1'b0, quo_reg[D][c]})
                                     : signed'({1'b0, quo_reg[D][c]});
            case (dsel_reg[D][c/2])
                tpq_pkg::SEL_START: ept_c[c] = vs_c;
                tpq_pkg::SEL_END:   ept_c[c] = ve_c;
                tpq_pkg::SEL_PROJ:  ept_c[c] = C'((D+1)'(vs_c) + qs_c[c]);
                default:            ept_c[c] = vs_c;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1v_reg <= 1'b0;
        end
        else
        begin
            e1v_reg <= dv_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        e1ins_reg  <= dins_reg[D];
        e1near_reg <= dnear_reg[D];
        e1px_reg   <= dpx_reg[D];
        e1py_reg   <= dpy_reg[D];
        for (int c = 0; c < 6; c++)
        begin
            ept_reg[c] <= ept_c[c];
        end
    end

    // ---------------- Post 2: squared offsets ----------------
    logic                e2v_reg, e2ins_reg, e2near_reg;
    logic signed [C-1:0] e2pt_reg [0:5];
    logic signed [P-1:0] sq_reg   [0:5];
    logic signed [D-1:0] off_c    [0:5];

    always_comb
    begin
        for (int c = 0; c < 6; c++)
        begin
            off_c[c] = {ept_reg[c][C-1], ept_reg[c]} - ((c % 2 == 0) ? e1px_reg : e1py_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2v_reg <= 1'b0;
        end
        else
        begin
            e2v_reg <= e1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e2ins_reg  <= e1ins_reg;
        e2near_reg <= e1near_reg;
        for (int c = 0; c < 6; c++)
        begin
            e2pt_reg[c] <= ept_reg[c];
            sq_reg[c]   <= off_c[c] * off_c[c];
        end
    end

    // ---------------- Post 3: pick the nearest edge ----------------
    logic [S-1:0]        dsq_c [0:2];
    logic [S-1:0]        best_c;
    logic signed [C-1:0] bx_c, by_c;
    logic                done_reg, inside_reg, near_reg;
    logic signed [C-1:0] cx_reg, cy_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            dsq_c[e] = S'(unsigned'(sq_reg[2*e])) + S'(unsigned'(sq_reg[2*e + 1]));
        end
        best_c = dsq_c[0];
        bx_c   = e2pt_reg[0];
        by_c   = e2pt_reg[1];
        // Strict compare keeps the earlier edge on a tie.
        for (int e = 1; e < 3; e++)
        begin
            if (dsq_c[e] < best_c)
            begin
                best_c = dsq_c[e];
                bx_c   = e2pt_reg[2*e];
                by_c   = e2pt_reg[2*e + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= e2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= e2ins_reg;
        near_reg   <= e2near_reg;
        cx_reg     <= bx_c;
        cy_reg     <= by_c;
    end

    assign done        = done_reg;
    assign inside_res  = inside_reg;
    assign near_vertex = near_reg;
    assign closest_x   = cx_reg;
    assign closest_y   = cy_reg;

    // ---------------- Assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result beat without a query beat at the pipeline latency");

    a_rem_ab_x: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[D] && dsel_reg[D][0] == tpq_pkg::SEL_PROJ)
            |-> (rem_reg[D][0] < N'(dlen_reg[D][0])))
        else $error("divider remainder not below edge length on AB");

    a_rem_bc_y: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[D] && dsel_reg[D][2] == tpq_pkg::SEL_PROJ)
            |-> (rem_reg[D][5] < N'(dlen_reg[D][2])))
        else $error("divider remainder not below edge length on BC");

endmodule

### sim/tpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle point query checker
// Watches the configuration port, the query channel and the result strobe,
// works out the expected inside flag, near-vertex flag and closest edge point
// for every accepted query beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module tpq_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [tpq_pkg::IDX_W-1:0]             cfg_index,
    input  logic [tpq_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] query_y,
    input  logic                                  done,
    input  logic                                  inside_res,
    input  logic                                  near_vertex,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] closest_x,
    input  logic signed [tpq_pkg::COORD_BITS-1:0] closest_y,
    output int                                    pending,
    output int                                    errors
);

    localparam int CB = tpq_pkg::COORD_BITS;

    typedef struct packed {
        logic                 in_tri;
        logic                 near;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
    } answer_t;

    answer_t answers_due[$];
    logic signed [CB-1:0] vtx_x [3];
    logic signed [CB-1:0] vtx_y [3];
    logic [tpq_pkg::LIM_W-1:0] near_limit;

    assign pending = answers_due.size();

    function automatic longint side_cross(longint px, longint py, longint sx, longint sy,
                                          longint ex, longint ey);
        return (ex - sx) * (py - sy) - (px - sx) * (ey - sy);
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic answer_t predict_query(longint px, longint py);
        answer_t r;
        longint ex [3];
        longint ey [3];
        longint sx, sy, fx, fy, dx, dy, len, dot, best, d;
        int s, e, o;
        r.in_tri = 1'b1;
        r.near = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s = (k == 2) ? 1 : 0;
            e = (k == 0) ? 1 : 2;
            o = 3 - s - e;
            sx = longint'(vtx_x[s]);
            sy = longint'(vtx_y[s]);
            fx = longint'(vtx_x[e]);
            fy = longint'(vtx_y[e]);
            if (sgn(side_cross(px, py, sx, sy, fx, fy))
                * sgn(side_cross(longint'(vtx_x[o]), longint'(vtx_y[o]), sx, sy, fx, fy)) < 0)
                r.in_tri = 1'b0;
            if (sq_dist(longint'(vtx_x[k]), longint'(vtx_y[k]), px, py)
                < longint'(near_limit))
                r.near = 1'b1;
            dx = fx - sx; dy = fy - sy;
            len = dx * dx + dy * dy;
            dot = (px - sx) * dx + (py - sy) * dy;
            if (len == 0 || dot < 0) begin
                ex[k] = sx; ey[k] = sy;
            end else if (dot > len) begin
                ex[k] = fx; ey[k] = fy;
            end else begin
                // SystemVerilog division truncates toward zero, as wanted.
                ex[k] = sx + (dx * dot) / len;
                ey[k] = sy + (dy * dot) / len;
            end
        end
        r.cx = CB'(ex[0]); r.cy = CB'(ey[0]);
        best = sq_dist(ex[0], ey[0], px, py);
        for (int k = 1; k < 3; k++) begin
            d = sq_dist(ex[k], ey[k], px, py);
            if (d < best) begin
                best = d; r.cx = CB'(ex[k]); r.cy = CB'(ey[k]);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        answer_t want;
        if (!rst_n) begin
            for (int k = 0; k < 3; k++) begin
                vtx_x[k] <= '0;
                vtx_y[k] <= '0;
            end
            near_limit <= tpq_pkg::LIM_RESET;
            answers_due.delete();
            errors = 0;
        end else begin
            // The query beat is evaluated against the registers before this edge's write.
            if (start && !busy)
                answers_due.insert(answers_due.size(),
                                   predict_query(longint'(query_x), longint'(query_y)));
            if (done) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result beat with no query outstanding", $realtime);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (inside_res !== want.in_tri)
                        report_mismatch("inside_res", inside_res, want.in_tri);
                    if (near_vertex !== want.near)
                        report_mismatch("near_vertex", near_vertex, want.near);
                    if (closest_x !== want.cx)
                        report_mismatch("closest_x", closest_x, want.cx);
                    if (closest_y !== want.cy)
                        report_mismatch("closest_y", closest_y, want.cy);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    tpq_pkg::REG_A_X: vtx_x[0] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_A_Y: vtx_y[0] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_B_X: vtx_x[1] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_B_Y: vtx_y[1] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_C_X: vtx_x[2] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_C_Y: vtx_y[2] <= cfg_data[CB-1:0];
                    tpq_pkg::REG_LIM: near_limit <= cfg_data[tpq_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle point query testbench
// Loads a series of triangles and thresholds, from degenerate to full-range,
// and streams directed and random query points, some with random gaps; the checker
// compares every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY     = tpq_pkg::COORD_BITS + 9;
    localparam int STALL_LIMIT = 2000;
    localparam int CW          = tpq_pkg::CFG_W;

    // An index past the last register; writes to it must be ignored.
    localparam logic [tpq_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [tpq_pkg::IDX_W-1:0] cfg_index;
    logic [tpq_pkg::CFG_W-1:0] cfg_data;
    logic start;
    logic busy;
    logic signed [tpq_pkg::COORD_BITS-1:0] query_x;
    logic signed [tpq_pkg::COORD_BITS-1:0] query_y;
    logic done;
    logic inside_res;
    logic near_vertex;
    logic signed [tpq_pkg::COORD_BITS-1:0] closest_x;
    logic signed [tpq_pkg::COORD_BITS-1:0] closest_y;
    int pending;
    int errors;
    int idle_pct;
    int quiet_cycles;

    triangle_point_query dut (.*);

    tpq_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: cycles with neither a query beat nor a result beat.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [tpq_pkg::IDX_W-1:0] idx,
                             input logic [tpq_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_triangle(input logic [15:0] ax, ay, bx, by, cx, cy,
                                 input logic [31:0] lim);
        drain();
        write_reg(tpq_pkg::REG_A_X, CW'(ax));
        write_reg(tpq_pkg::REG_A_Y, CW'(ay));
        write_reg(tpq_pkg::REG_B_X, CW'(bx));
        write_reg(tpq_pkg::REG_B_Y, CW'(by));
        write_reg(tpq_pkg::REG_C_X, CW'(cx));
        write_reg(tpq_pkg::REG_C_Y, CW'(cy));
        write_reg(tpq_pkg::REG_LIM, CW'(lim));
        write_reg(REG_UNUSED, CW'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Holds start high across back-to-back beats; idles only when asked.
    task automatic send_query(input logic [15:0] qx, qy);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        query_x <= qx;
        query_y <= qy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [15:0] near_coord(input logic [15:0] base, input int span);
        return base + 16'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    task automatic random_queries(input int n);
        logic [15:0] v [6];
        logic [15:0] qx, qy;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                for (int k = 0; k < 6; k++)
                    v[k] = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(2048, 0) - 1024);
                if (i % 240 == 120) begin
                    v[2] = v[0];
                    v[3] = v[1];
                end
                load_triangle(v[0], v[1], v[2], v[3], v[4], v[5],
                              ($urandom_range(1, 0) != 0) ? 32'($urandom_range(90000, 0))
                                                          : 32'($urandom));
            end
            case ($urandom_range(3, 0))
                0: begin
                    qx = 16'($urandom);
                    qy = 16'($urandom);
                end
                1: begin
                    qx = near_coord(v[2 * $urandom_range(2, 0)], 8);
                    qy = near_coord(v[1], 300);
                end
                default: begin
                    qx = near_coord(v[0], 512);
                    qy = near_coord(v[5], 512);
                end
            endcase
            send_query(qx, qy);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        query_x   = '0;
        query_y   = '0;
        idle_pct  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset triangle: every vertex at the origin, limit 7.
        send_query(16'h0000, 16'h0000);
        send_query(16'h0002, 16'h0001);
        send_query(16'h7fff, 16'h8000);

        load_triangle(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400, 32'd256);
        send_query(16'h0100, 16'h0100);
        send_query(16'h0200, 16'h0000);
        send_query(16'h0200, 16'h0200);
        send_query(16'hff00, 16'hff00);
        send_query(16'h0500, 16'h0300);
        send_query(16'h0003, 16'h0003);
        send_query(16'h0010, 16'h0010);

        // Zero-length edge and a collinear triangle.
        load_triangle(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0300, 16'h0300, 32'd0);
        send_query(16'h0200, 16'h0100);
        send_query(16'h0000, 16'h0500);
        send_query(16'h0400, 16'h0400);

        load_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                      32'hffff_ffff);
        send_query(16'h7fff, 16'h7fff);
        send_query(16'h8000, 16'h8000);
        send_query(16'h0000, 16'h0000);
        send_query(16'h7fff, 16'h8000);
        send_query(16'h5555, 16'haaaa);

        load_triangle(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 32'h8000_0000);
        send_query(16'h8000, 16'h7fff);
        send_query(16'h0000, 16'h0001);
        send_query(16'haaaa, 16'h5555);

        idle_pct = 11;
        random_queries(360);
        drain();
        idle_pct = 54;
        random_queries(360);
        idle_pct = 0;
        random_queries(360);
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/tpq_pkg.sv
rtl/triangle_point_query.sv
sim/tpq_checker.sv
sim/tb_top.sv
